/* hw/rtl/fpu_pkg.sv */
// Shared types and constants for the flash page upload parser.
`timescale 1ns / 1ps

package fpu_pkg;

    localparam logic [7:0]  START_CHAR     = 8'h24;
    localparam logic [15:0] ENTRY_BIAS     = 16'hBFFF;
    localparam logic [15:0] PROT_START_RST = 16'h1800;
    localparam int          RESET_WORD_IDX = 0;
    localparam int          INT0_WORD_IDX  = 1;

    localparam logic [1:0]  CFG_SAVED_RESET = 2'd0;
    localparam logic [1:0]  CFG_SAVED_INT0  = 2'd1;
    localparam logic [1:0]  CFG_PROT_START  = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_CHECK  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        K_FILL   = 3'd0,
        K_COMMIT = 3'd1,
        K_DONE   = 3'd2,
        K_RANGE  = 3'd3,
        K_CSUM   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [15:0] word;
        logic [15:0] entry;
        logic        last;
    } t_result;

    typedef struct packed {
        logic    p0;
        logic    p1;
        t_result r0;
        t_result r1;
    } t_push;

endpackage

/* hw/rtl/fpu_parser.sv */
// Byte parser: header, page data, checksum and vector substitution.
`timescale 1ns / 1ps

module fpu_parser
    import fpu_pkg::*;
#(
    parameter int PAGE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_saved_reset_word,
    input  logic [15:0] i_saved_int0_word,
    input  logic [15:0] i_protected_start,
    output t_push       o_push
);

    localparam int WORDS = PAGE_BYTES / 2;
    localparam int IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PROD_W = 16 + $clog2(PAGE_BYTES + 1);
    localparam int SUM_W = PROD_W + 1;

    t_phase         r_phase, n_phase;
    logic [1:0]     r_hdr_cnt, n_hdr_cnt;
    logic [15:0]    r_page_addr, n_page_addr;
    logic [15:0]    r_pages_total, n_pages_total;
    logic [15:0]    r_pages_done, n_pages_done;
    logic [IDX_W-1:0] r_word_idx, n_word_idx;
    logic [7:0]     r_low_hold, n_low_hold;
    logic           r_high_pend, n_high_pend;
    logic [7:0]     r_xor, n_xor;
    logic [15:0]    r_entry, n_entry;

    logic [15:0]    w_pt_new;
    logic [SUM_W-1:0] w_end;
    logic           w_range_fail;
    logic [15:0]    w_word;
    logic [15:0]    w_fill_addr;
    logic [15:0]    w_done_cnt;
    logic [7:0]     w_xor_new;

    assign w_pt_new     = {r_pages_total[15:8], i_byte};
    assign w_end        = SUM_W'(r_page_addr) + SUM_W'(w_pt_new) * SUM_W'(PAGE_BYTES);
    assign w_range_fail = w_end >= SUM_W'(i_protected_start);
    assign w_fill_addr  = 16'(r_page_addr + {15'(r_word_idx), 1'b0});
    assign w_done_cnt   = 16'(r_pages_done + 16'd1);
    assign w_xor_new    = r_xor ^ i_byte;

    always_comb begin
        n_phase       = r_phase;
        n_hdr_cnt     = r_hdr_cnt;
        n_page_addr   = r_page_addr;
        n_pages_total = r_pages_total;
        n_pages_done  = r_pages_done;
        n_word_idx    = r_word_idx;
        n_low_hold    = r_low_hold;
        n_high_pend   = r_high_pend;
        n_xor         = r_xor;
        n_entry       = r_entry;
        w_word        = {i_byte, r_low_hold};
        o_push        = '0;
        o_push.r0.last = 1'b1;
        o_push.r1.last = 1'b1;
        if (i_accept) begin
            unique case (r_phase)
                PH_IDLE: begin
                    if (i_byte == START_CHAR) begin
                        n_phase      = PH_HEADER;
                        n_hdr_cnt    = 2'd0;
                        n_pages_done = '0;
                        n_word_idx   = '0;
                        n_high_pend  = 1'b0;
                        n_xor        = '0;
                    end
                end
                PH_HEADER: begin
                    unique case (r_hdr_cnt)
                        2'd0: n_page_addr   = {i_byte, r_page_addr[7:0]};
                        2'd1: n_page_addr   = {r_page_addr[15:8], i_byte};
                        2'd2: n_pages_total = {i_byte, r_pages_total[7:0]};
                        2'd3: n_pages_total = w_pt_new;
                    endcase
                    if (r_hdr_cnt != 2'd3) begin
                        n_hdr_cnt = 2'(r_hdr_cnt + 2'd1);
                    end else begin
                        n_hdr_cnt = 2'd0;
                        if (w_range_fail) begin
                            n_phase        = PH_IDLE;
                            o_push.p0      = 1'b1;
                            o_push.r0.kind = K_RANGE;
                        end else if (w_pt_new == 16'd0) begin
                            n_phase         = PH_IDLE;
                            o_push.p0       = 1'b1;
                            o_push.r0.kind  = K_DONE;
                            o_push.r0.entry = r_entry;
                        end else begin
                            n_phase     = PH_DATA;
                            n_word_idx  = '0;
                            n_high_pend = 1'b0;
                            n_xor       = '0;
                        end
                    end
                end
                PH_DATA: begin
                    n_xor = w_xor_new;
                    if (!r_high_pend) begin
                        n_low_hold  = i_byte;
                        n_high_pend = 1'b1;
                    end else begin
                        n_high_pend = 1'b0;
                        if (r_page_addr == 16'd0) begin
                            if (r_word_idx == IDX_W'(RESET_WORD_IDX)) begin
                                n_entry = 16'({i_byte, r_low_hold} - ENTRY_BIAS);
                                w_word  = i_saved_reset_word;
                            end else if (r_word_idx == IDX_W'(INT0_WORD_IDX)) begin
                                w_word  = i_saved_int0_word;
                            end
                        end
                        o_push.p0      = 1'b1;
                        o_push.r0.kind = K_FILL;
                        o_push.r0.addr = w_fill_addr;
                        o_push.r0.word = w_word;
                        if (r_word_idx == IDX_W'(WORDS - 1)) begin
                            n_word_idx = '0;
                            n_phase    = PH_CHECK;
                        end else begin
                            n_word_idx = IDX_W'(r_word_idx + 1'b1);
                        end
                    end
                end
                PH_CHECK: begin
                    o_push.p0 = 1'b1;
                    if (i_byte != r_xor) begin
                        n_phase        = PH_IDLE;
                        o_push.r0.kind = K_CSUM;
                    end else begin
                        n_pages_done   = w_done_cnt;
                        n_page_addr    = 16'(r_page_addr + 16'(PAGE_BYTES));
                        n_xor          = '0;
                        o_push.r0.kind = K_COMMIT;
                        o_push.r0.addr = r_page_addr;
                        if (w_done_cnt >= r_pages_total) begin
                            n_phase         = PH_IDLE;
                            o_push.r0.last  = 1'b0;
                            o_push.p1       = 1'b1;
                            o_push.r1.kind  = K_DONE;
                            o_push.r1.entry = r_entry;
                        end else begin
                            n_phase = PH_DATA;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_hdr_cnt     <= '0;
            r_page_addr   <= '0;
            r_pages_total <= '0;
            r_pages_done  <= '0;
            r_word_idx    <= '0;
            r_low_hold    <= '0;
            r_high_pend   <= 1'b0;
            r_xor         <= '0;
            r_entry       <= '0;
        end else begin
            r_phase       <= n_phase;
            r_hdr_cnt     <= n_hdr_cnt;
            r_page_addr   <= n_page_addr;
            r_pages_total <= n_pages_total;
            r_pages_done  <= n_pages_done;
            r_word_idx    <= n_word_idx;
            r_low_hold    <= n_low_hold;
            r_high_pend   <= n_high_pend;
            r_xor         <= n_xor;
            r_entry       <= n_entry;
        end
    end

endmodule

/* hw/rtl/fpu_res_fifo.sv */
// Result queue: takes up to two results per cycle, hands out one result at a time as the receiver takes it.
`timescale 1ns / 1ps

module fpu_res_fifo
    import fpu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    output logic    o_room2,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, n_wr;
    logic [PTR_W-1:0]   r_rd, n_rd;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_pop;

    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign o_room2 = r_cnt <= CNT_W'(DEPTH - 2);
    assign w_pop   = o_valid && i_ready;

    always_comb begin
        n_wr  = PTR_W'(r_wr + PTR_W'(i_push.p0) + PTR_W'(i_push.p1));
        n_rd  = PTR_W'(r_rd + PTR_W'(w_pop));
        n_cnt = CNT_W'(r_cnt + CNT_W'(i_push.p0) + CNT_W'(i_push.p1) - CNT_W'(w_pop));
    end

    always_ff @(posedge i_clk) begin
        if (i_push.p0) begin
            r_mem[r_wr] <= i_push.r0;
        end
        if (i_push.p1) begin
            r_mem[PTR_W'(r_wr + 1'b1)] <= i_push.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* hw/rtl/flash_page_upload_parser.sv */
// Flash page upload parser top level: config registers, parser and result queue.
//
// Usage:
//   Received bytes enter on the rx channel (i_rx_valid / o_rx_ready / i_rx_byte),
//   one byte per cycle while o_rx_ready is high. Each byte updates the parser
//   state in the cycle it is accepted and queues zero, one or two results (fill,
//   commit, done, range fail, checksum fail). Results leave on the result channel
//   (o_res_valid / i_res_ready) one per cycle while i_res_ready is high, each
//   registered in the result queue first. Throughput is one byte per cycle while
//   o_rx_ready is high; a checksum byte that finishes the last page queues two results.
//   The four-entry result queue decouples the sides: o_rx_ready is high while
//   at least two entries are free, so a stalled receiver back-pressures the
//   byte stream once more than two entries are held.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   the next edge; index 3 is ignored.
//   Synchronous active-low reset returns the parser to idle, empties the queue
//   and restores the configuration defaults (protected start 0x1800).
`timescale 1ns / 1ps

module flash_page_upload_parser
    import fpu_pkg::*;
#(
    parameter int PAGE_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [2:0]  o_kind,
    output logic [15:0] o_flash_addr,
    output logic [15:0] o_flash_word,
    output logic [15:0] o_app_entry,
    output logic        o_last
);

    logic [15:0] r_saved_reset;
    logic [15:0] r_saved_int0;
    logic [15:0] r_prot_start;
    t_push       w_push;
    t_result     w_res;
    logic        w_room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_saved_reset <= '0;
            r_saved_int0  <= '0;
            r_prot_start  <= PROT_START_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAVED_RESET: r_saved_reset <= i_cfg_data;
                CFG_SAVED_INT0:  r_saved_int0  <= i_cfg_data;
                CFG_PROT_START:  r_prot_start  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_rx_ready = w_room2;

    fpu_parser #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_parser (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (i_rx_valid && w_room2),
        .i_byte             (i_rx_byte),
        .i_saved_reset_word (r_saved_reset),
        .i_saved_int0_word  (r_saved_int0),
        .i_protected_start  (r_prot_start),
        .o_push             (w_push)
    );

    fpu_res_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room2 (w_room2),
        .o_valid (o_res_valid),
        .i_ready (i_res_ready),
        .o_data  (w_res)
    );

    assign o_kind       = w_res.kind;
    assign o_flash_addr = w_res.addr;
    assign o_flash_word = w_res.word;
    assign o_app_entry  = w_res.entry;
    assign o_last       = w_res.last;

endmodule

/* tb/sv/flash_page_upload_parser_test.sv */
// Self-checking testbench for the flash page upload parser.
`timescale 1ns / 1ps

import fpu_pkg::*;

localparam int PAGE_BYTES = 64;
localparam logic [1:0] CFG_NONE = 2'd3;

class upload_scoreboard;
    t_result     due[$];
    int          mismatches;
    int          checked;
    int          parsed;
    logic [15:0] saved_reset;
    logic [15:0] saved_int0;
    logic [15:0] prot_start;
    t_phase      phase;
    logic [1:0]  hdr_count;
    logic [15:0] page_addr;
    logic [15:0] pages_total;
    logic [15:0] pages_done;
    logic [7:0]  word_idx;
    logic [7:0]  low_hold;
    logic        high_pending;
    logic [7:0]  xsum;
    logic [15:0] entry;

    function void clear();
        due.delete();
        saved_reset  = '0;
        saved_int0   = '0;
        prot_start   = PROT_START_RST;
        phase        = PH_IDLE;
        hdr_count    = '0;
        page_addr    = '0;
        pages_total  = '0;
        pages_done   = '0;
        word_idx     = '0;
        low_hold     = '0;
        high_pending = 1'b0;
        xsum         = '0;
        entry        = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_SAVED_RESET: saved_reset = val;
            CFG_SAVED_INT0:  saved_int0 = val;
            CFG_PROT_START:  prot_start = val;
            default: ;
        endcase
    endfunction

    function void push(t_kind k, logic [15:0] a, logic [15:0] w, logic [15:0] e, logic l);
        t_result r;
        r.kind  = k;
        r.addr  = a;
        r.word  = w;
        r.entry = e;
        r.last  = l;
        due.push_back(r);
    endfunction

    // one received byte through the parser
    function void take_byte(logic [7:0] b);
        logic [31:0] reach;
        logic [15:0] w;
        logic [15:0] a;
        if (phase != PH_IDLE || b == START_CHAR)
            parsed++;
        case (phase)
            PH_IDLE: begin
                if (b == START_CHAR) begin
                    phase        = PH_HEADER;
                    hdr_count    = '0;
                    pages_done   = '0;
                    word_idx     = '0;
                    high_pending = 1'b0;
                    xsum         = '0;
                end
            end
            PH_HEADER: begin
                case (hdr_count)
                    2'd0:    page_addr[15:8] = b;
                    2'd1:    page_addr[7:0] = b;
                    2'd2:    pages_total[15:8] = b;
                    default: pages_total[7:0] = b;
                endcase
                if (hdr_count != 2'd3) begin
                    hdr_count = hdr_count + 2'd1;
                end else begin
                    hdr_count = '0;
                    reach = {16'd0, page_addr} + {16'd0, pages_total} * 32'(PAGE_BYTES);
                    if (reach >= {16'd0, prot_start}) begin
                        phase = PH_IDLE;
                        push(K_RANGE, '0, '0, '0, 1'b1);
                    end else if (pages_total == '0) begin
                        phase = PH_IDLE;
                        push(K_DONE, '0, '0, entry, 1'b1);
                    end else begin
                        phase        = PH_DATA;
                        word_idx     = '0;
                        high_pending = 1'b0;
                        xsum         = '0;
                    end
                end
            end
            PH_DATA: begin
                xsum = xsum ^ b;
                if (!high_pending) begin
                    low_hold     = b;
                    high_pending = 1'b1;
                end else begin
                    high_pending = 1'b0;
                    w = {b, low_hold};
                    a = page_addr + {7'd0, word_idx, 1'b0};
                    if (page_addr == '0) begin
                        if (word_idx == RESET_WORD_IDX) begin
                            entry = w - ENTRY_BIAS;
                            w     = saved_reset;
                        end else if (word_idx == INT0_WORD_IDX) begin
                            w = saved_int0;
                        end
                    end
                    push(K_FILL, a, w, '0, 1'b1);
                    word_idx = word_idx + 8'd1;
                    if (word_idx >= PAGE_BYTES / 2) begin
                        word_idx = '0;
                        phase    = PH_CHECK;
                    end
                end
            end
            default: begin
                if (b != xsum) begin
                    phase = PH_IDLE;
                    push(K_CSUM, '0, '0, '0, 1'b1);
                end else begin
                    a          = page_addr;
                    pages_done = pages_done + 16'd1;
                    page_addr  = page_addr + 16'(PAGE_BYTES);
                    xsum       = '0;
                    if (pages_done >= pages_total) begin
                        phase = PH_IDLE;
                        push(K_COMMIT, a, '0, '0, 1'b0);
                        push(K_DONE, '0, '0, entry, 1'b1);
                    end else begin
                        phase = PH_DATA;
                        push(K_COMMIT, a, '0, '0, 1'b1);
                    end
                end
            end
        endcase
    endfunction

    function void check_result(t_result got);
        t_result exp;
        checked++;
        if (due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d addr %h word %h entry %h last %b",
                         got.kind, got.addr, got.word, got.entry, got.last);
        end else begin
            exp = due.pop_front();
            if (got.kind != exp.kind || got.addr != exp.addr || got.word != exp.word ||
                    got.entry != exp.entry || got.last != exp.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp kind %0d addr %h word %h entry %h last %b,",
                             exp.kind, exp.addr, exp.word, exp.entry, exp.last,
                             " got kind %0d addr %h word %h entry %h last %b",
                             got.kind, got.addr, got.word, got.entry, got.last);
            end
        end
    endfunction

    function int pending();
        return due.size();
    endfunction
endclass

module flash_page_upload_parser_test;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_rx_valid = 1'b0;
    logic        o_rx_ready;
    logic [7:0]  i_rx_byte = '0;
    logic        o_res_valid;
    logic        i_res_ready = 1'b0;
    logic [2:0]  o_kind;
    logic [15:0] o_flash_addr;
    logic [15:0] o_flash_word;
    logic [15:0] o_app_entry;
    logic        o_last;

    upload_scoreboard sb = new;
    logic [15:0]      prot_now = PROT_START_RST;
    bit               sender_calm = 1'b0;

    flash_page_upload_parser #(
        .PAGE_BYTES(PAGE_BYTES)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_rx_valid(i_rx_valid),
        .o_rx_ready(o_rx_ready),
        .i_rx_byte(i_rx_byte),
        .o_res_valid(o_res_valid),
        .i_res_ready(i_res_ready),
        .o_kind(o_kind),
        .o_flash_addr(o_flash_addr),
        .o_flash_word(o_flash_word),
        .o_app_entry(o_app_entry),
        .o_last(o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            sb.clear();
        end else begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_index, i_cfg_data);
            if (i_rx_valid && o_rx_ready)
                sb.take_byte(i_rx_byte);
            if (o_res_valid && i_res_ready) begin
                got.kind  = t_kind'(o_kind);
                got.addr  = o_flash_addr;
                got.word  = o_flash_word;
                got.entry = o_app_entry;
                got.last  = o_last;
                sb.check_result(got);
            end
        end
    end

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
    endtask

    task automatic send_page(input bit corrupt);
        logic [7:0] d;
        logic [7:0] sum;
        sum = '0;
        for (int i = 0; i < PAGE_BYTES; i++) begin
            d   = 8'($urandom_range(0, 255));
            sum = sum ^ d;
            send_byte(d);
        end
        if (corrupt)
            sum = sum ^ (8'd1 << $urandom_range(0, 7));
        send_byte(sum);
    endtask

    // '$', header, then the pages if the range check lets them in, up to and including the bad page
    task automatic send_upload(input logic [15:0] addr, input logic [15:0] pages,
                               input int bad_page);
        logic [31:0] reach;
        send_byte(START_CHAR);
        send_byte(addr[15:8]);
        send_byte(addr[7:0]);
        send_byte(pages[15:8]);
        send_byte(pages[7:0]);
        reach = {16'd0, addr} + {16'd0, pages} * 32'(PAGE_BYTES);
        if (reach < {16'd0, prot_now}) begin
            for (int p = 0; p < int'(pages); p++) begin
                send_page(p == bad_page);
                if (p == bad_page)
                    break;
            end
        end
    endtask

    task automatic send_noise();
        logic [7:0] d;
        repeat ($urandom_range(1, 4)) begin
            do d = 8'($urandom_range(0, 255)); while (d == START_CHAR);
            send_byte(d);
        end
    endtask

    task automatic settle();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        if (idx == CFG_PROT_START)
            prot_now = val;
    endtask

    task automatic load_regs(input logic [15:0] sr, input logic [15:0] si,
                             input logic [15:0] ps);
        write_reg(CFG_SAVED_RESET, sr);
        write_reg(CFG_SAVED_INT0, si);
        write_reg(CFG_PROT_START, ps);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_uploads(input int quota, input bit calm);
        int          target;
        int          r;
        int          limit;
        int          bad;
        logic [15:0] addr;
        logic [15:0] pages;
        sender_calm = calm;
        target = sb.parsed + quota;
        send_upload(16'h0000, 16'd2, -1);
        while (sb.parsed < target) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_noise();
            end else if (r < 18) begin
                pages = 16'($urandom_range(0, 3));
                if ($urandom_range(0, 2) == 0 && int'(prot_now) >= int'(pages) * PAGE_BYTES) begin
                    addr = prot_now - pages * 16'(PAGE_BYTES);
                end else begin
                    addr  = 16'($urandom_range(0, 65535));
                    pages = 16'($urandom_range(0, 65535));
                    if ({16'd0, addr} + {16'd0, pages} * 32'(PAGE_BYTES) < {16'd0, prot_now})
                        pages = 16'hFFFF;
                end
                send_upload(addr, pages, -1);
            end else begin
                r = $urandom_range(0, 99);
                pages = (r < 10) ? 16'd0 : (r < 60) ? 16'd1 : (r < 90) ? 16'd2 :
                        16'($urandom_range(3, 4));
                limit = int'(prot_now) - int'(pages) * PAGE_BYTES;
                if (limit <= 0) begin
                    pages = 16'd0;
                    limit = int'(prot_now);
                end
                r = $urandom_range(0, 99);
                if (r < 20)
                    addr = '0;
                else if (r < 30)
                    addr = 16'(limit - 1);
                else
                    addr = 16'($urandom_range(0, limit - 1));
                bad = -1;
                if (pages != 0 && $urandom_range(0, 99) < 15)
                    bad = $urandom_range(0, int'(pages) - 1);
                send_upload(addr, pages, bad);
            end
        end
        settle();
    endtask

    initial begin
        int run;
        int stall;
        bit squeezed;
        squeezed = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_res_ready <= 1'b1;
            run = $urandom_range(1, 30);
            repeat (run) @(posedge i_clk);
            if (!squeezed && sb.checked >= 300 && i_rx_valid) begin
                squeezed = 1'b1;
                stall = 400;
            end else begin
                stall = pick_gap(1'b0);
            end
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("flash_page_upload_parser_test NOT OK");
        $finish;
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: ignored bytes, header-only outcomes at the default limit
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_CHAR - 8'd1);
        send_upload(16'h0000, 16'h0000, -1);
        send_upload(16'hFFFF, 16'hFFFF, -1);
        send_upload(16'h17C0, 16'h0001, -1);
        send_upload(16'h17FF, 16'h0000, -1);
        send_upload(16'h1800, 16'h0000, -1);
        settle();

        // zero protected start refuses everything; unmapped index is ignored
        write_reg(CFG_NONE, 16'($urandom_range(0, 65535)));
        load_regs(16'hFFFF, 16'h0000, 16'h0000);
        send_upload(16'h0000, 16'h0000, -1);
        settle();

        load_regs(16'h0000, 16'hFFFF, 16'hFFFF);
        run_uploads(250, 1'b0);

        load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(16'h0200, 16'hFFFF)));
        run_uploads(250, 1'b1);

        load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 16'h0100);
        run_uploads(250, 1'b0);

        load_regs(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                  PROT_START_RST);
        run_uploads(250, 1'b0);

        repeat (10) @(posedge i_clk);
        if (sb.mismatches + sb.pending() == 0)
            $display("flash_page_upload_parser_test OK");
        else
            $display("flash_page_upload_parser_test NOT OK");
        $finish;
    end

endmodule
